FILE: design/life_grid_generation_step_assert.svh
// ----------------------------------------------------------------------------
// life_grid_generation_step assertion macros
// Clocked property helpers used by the grid stepper top level to check itself.
// ----------------------------------------------------------------------------
`ifndef LIFE_GRID_GENERATION_STEP_ASSERT_SVH
`define LIFE_GRID_GENERATION_STEP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LGS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LGS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/lgs_pkg.sv
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared constants, mode codes and control structs of the grid stepper.
// ----------------------------------------------------------------------------
package lgs_pkg;

    localparam int ROWS_DEFAULT = 16;
    localparam int COLS_DEFAULT = 16;

    localparam logic [1:0] MODE_WRITE   = 2'd0;
    localparam logic [1:0] MODE_ADVANCE = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;

    // B3/S23 neighbor counts
    localparam logic [3:0] NBR_BIRTH = 4'd3;
    localparam logic [3:0] NBR_KEEP  = 4'd2;

    typedef struct packed {
        logic host_wr;    // write row from input transaction
        logic host_rd;    // issue read of selected row
        logic adv_start;  // issue read of row 0, clear row above, counter and change flag
        logic prime;      // load middle row, issue read of row 1
        logic adv_step;   // emit next row, write back, slide window
        logic rd_out;     // emit read result
    } lgs_cmd_t;

    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic adv_last;   // row counter on last row
    } lgs_status_t;

endpackage

FILE: design/life_grid_generation_step.sv
// ----------------------------------------------------------------------------
// life_grid_generation_step
// Game of Life grid (B3/S23, dead border): row write, row read, one-generation
// sweep reporting every new row.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  input   | in_valid / in_stall  | mode, row_select, row_cells
//  output  | out_valid / out_stall| row_number, row_state, row_changed,
//          |                      | any_changed, last
//
//  Write: no result. Read: the result goes through the registered memory read port.
//  Advance: rows 0 and 1 are fetched first, then one row per cycle through the
//  three-row window while the output is not stalled, one result per row.
//  Reset clears the per-row valid bits, so the grid reads dead at once.
//  out_stall holds the sweep on the current row; input is stalled until the
//  transaction's last result is in the output register.
// ----------------------------------------------------------------------------
module life_grid_generation_step #(
    parameter int ROWS = lgs_pkg::ROWS_DEFAULT,
    parameter int COLS = lgs_pkg::COLS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [3:0]  row_select,
    input  logic [15:0] row_cells,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  row_number,
    output logic [15:0] row_state,
    output logic        row_changed,
    output logic        any_changed,
    output logic        last
);
    import lgs_pkg::*;

    lgs_cmd_t    cmd;
    lgs_status_t status;

    lgs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .status   (status),
        .cmd      (cmd)
    );

    lgs_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .row_select  (row_select),
        .row_cells   (row_cells),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .row_number  (row_number),
        .row_state   (row_state),
        .row_changed (row_changed),
        .any_changed (any_changed),
        .last        (last)
    );

`include "life_grid_generation_step_assert.svh"

    `LGS_ASSERT_SAME(a_step_needs_slot, cmd.adv_step || cmd.rd_out, status.out_free, "result issued into a full output register")
    `LGS_ASSERT_SAME(a_one_cmd, 1'b1, $onehot0(cmd), "more than one datapath command at once")
    `LGS_ASSERT_NEXT(a_sweep_ends_idle, cmd.adv_step && status.adv_last, !in_stall && out_valid && last, "sweep did not end with last result and idle")
    `LGS_ASSERT_SAME(a_any_only_last, out_valid && any_changed, last, "any_changed set on a non-final result")

endmodule

FILE: design/lgs_ctrl.sv
// ----------------------------------------------------------------------------
// lgs_ctrl
// Sequencer for row write, row read and generation sweep.
// ----------------------------------------------------------------------------
module lgs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           mode,
    input  lgs_pkg::lgs_status_t status,
    output lgs_pkg::lgs_cmd_t    cmd
);
    import lgs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_RD_WAIT = 4'b0010,
        S_PRIME   = 4'b0100,
        S_ADV     = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_WRITE:
                        begin
                            cmd.host_wr = 1'b1;
                        end
                        MODE_ADVANCE:
                        begin
                            cmd.adv_start = 1'b1;
                            state_next    = S_PRIME;
                        end
                        MODE_READ:
                        begin
                            cmd.host_rd = 1'b1;
                            state_next  = S_RD_WAIT;
                        end
                        default:
                        begin
                            // unused mode: dropped
                        end
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                if (status.out_free)
                begin
                    cmd.rd_out = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_PRIME:
            begin
                cmd.prime  = 1'b1;
                state_next = S_ADV;
            end
            S_ADV:
            begin
                if (status.out_free)
                begin
                    cmd.adv_step = 1'b1;
                    if (status.adv_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/lgs_datapath.sv
// ----------------------------------------------------------------------------
// lgs_datapath
// Grid row memory, three-row window, B3/S23 row update and output register.
// ----------------------------------------------------------------------------
module lgs_datapath #(
    parameter int ROWS = lgs_pkg::ROWS_DEFAULT,
    parameter int COLS = lgs_pkg::COLS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lgs_pkg::lgs_cmd_t    cmd,
    output lgs_pkg::lgs_status_t status,
    input  logic [3:0]           row_select,
    input  logic [15:0]          row_cells,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [3:0]           row_number,
    output logic [15:0]          row_state,
    output logic                 row_changed,
    output logic                 any_changed,
    output logic                 last
);
    import lgs_pkg::*;

    localparam int RW = $clog2(ROWS);

    // grid storage; a row never written reads as dead
    logic [COLS-1:0] mem [ROWS];
    logic [ROWS-1:0] row_vld_reg;

    logic [COLS-1:0] rd_data_reg;
    logic            rd_ok_reg;
    logic            rd_ok_next;
    logic [3:0]      rd_sel_reg;
    logic [COLS-1:0] rd_row;

    logic [COLS-1:0] above_reg;
    logic [COLS-1:0] mid_reg;
    logic [COLS-1:0] below;
    logic [RW-1:0]   r_reg;
    logic            any_reg;
    logic            any_next;

    logic            host_in_range;
    logic            step_rd_ok;
    logic            rd_en;
    logic [RW-1:0]   rd_addr;
    logic            wr_en;
    logic [RW-1:0]   wr_addr;
    logic [COLS-1:0] wr_data;

    logic [COLS+1:0] a_pad;
    logic [COLS+1:0] m_pad;
    logic [COLS+1:0] b_pad;
    logic [COLS-1:0] nrow;
    logic            changed;

    logic            out_valid_reg;
    logic            out_load;

    assign host_in_range   = (int'(row_select) < ROWS);
    assign step_rd_ok      = (int'(r_reg) + 2 < ROWS);
    assign status.adv_last = (int'(r_reg) == ROWS - 1);
    assign status.out_free = !out_valid_reg || !out_stall;

    // ---------------- memory ports ----------------
    assign rd_en = cmd.host_rd || cmd.adv_start || cmd.prime || (cmd.adv_step && step_rd_ok);

    always_comb
    begin
        if (cmd.host_rd)
        begin
            rd_addr = RW'(row_select);
        end
        else if (cmd.adv_start)
        begin
            rd_addr = '0;
        end
        else if (cmd.prime)
        begin
            rd_addr = RW'(1);
        end
        else
        begin
            rd_addr = r_reg + RW'(2);
        end
    end

    assign rd_ok_next = row_vld_reg[rd_addr] && (!cmd.host_rd || host_in_range);

    assign wr_en   = (cmd.host_wr && host_in_range) || cmd.adv_step;
    assign wr_addr = cmd.adv_step ? r_reg : RW'(row_select);
    assign wr_data = cmd.adv_step ? nrow : COLS'(row_cells);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (cmd.host_rd)
        begin
            rd_sel_reg <= row_select;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            rd_ok_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_ok_reg <= rd_ok_next;
            end
        end
    end

    assign rd_row = rd_ok_reg ? rd_data_reg : '0;
    // past the bottom edge the row below is dead
    assign below  = status.adv_last ? '0 : rd_row;

    // ---------------- generation update ----------------
    assign a_pad = {1'b0, above_reg, 1'b0};
    assign m_pad = {1'b0, mid_reg, 1'b0};
    assign b_pad = {1'b0, below, 1'b0};

    for (genvar c = 0; c < COLS; c++)
    begin : g_cell
        logic [3:0] cnt;
        assign cnt = 4'(a_pad[c]) + 4'(a_pad[c+1]) + 4'(a_pad[c+2])
                   + 4'(m_pad[c]) + 4'(m_pad[c+2])
                   + 4'(b_pad[c]) + 4'(b_pad[c+1]) + 4'(b_pad[c+2]);
        assign nrow[c] = (cnt == NBR_BIRTH) || (mid_reg[c] && (cnt == NBR_KEEP));
    end

    assign changed  = (nrow != mid_reg);
    assign any_next = any_reg | changed;

    always_ff @(posedge clk)
    begin
        if (cmd.adv_start)
        begin
            above_reg <= '0;
        end
        else if (cmd.adv_step)
        begin
            above_reg <= mid_reg;
        end
        if (cmd.prime)
        begin
            mid_reg <= rd_row;
        end
        else if (cmd.adv_step)
        begin
            mid_reg <= below;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg   <= '0;
            any_reg <= 1'b0;
        end
        else if (cmd.adv_start)
        begin
            r_reg   <= '0;
            any_reg <= 1'b0;
        end
        else if (cmd.adv_step)
        begin
            r_reg   <= r_reg + RW'(1);
            any_reg <= any_next;
        end
    end

    // ---------------- output register ----------------
    assign out_load = cmd.adv_step || cmd.rd_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.adv_step)
        begin
            row_number  <= 4'(r_reg);
            row_state   <= 16'(nrow);
            row_changed <= changed;
            any_changed <= status.adv_last ? any_next : 1'b0;
            last        <= status.adv_last;
        end
        else if (cmd.rd_out)
        begin
            row_number  <= rd_sel_reg;
            row_state   <= 16'(rd_row);
            row_changed <= 1'b0;
            any_changed <= 1'b0;
            last        <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
